// File: rtl/pcrw_pkg.sv
// Shared constants and types for the rectangular-window polygon clipper.
// No dependencies; pcrw_front, pcrw_stage, pcrw_emit and the top module import this package.
package pcrw_pkg;

    localparam int COORD_WIDTH_DEF = 16;   // signed Q12.4 by default
    localparam int MAX_RESULTS     = 16;   // results per input word, marker included
    localparam int CFG_IDX_W       = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 3'd3;

    localparam int RST_LEFT   = 2400;
    localparam int RST_TOP    = 2400;
    localparam int RST_RIGHT  = 5600;
    localparam int RST_BOTTOM = 4800;

    // Edge stage numbering, in cascade order
    localparam int STG_LEFT   = 0;
    localparam int STG_RIGHT  = 1;
    localparam int STG_TOP    = 2;
    localparam int STG_BOTTOM = 3;

    // Token kinds on the internal stage chain
    typedef enum logic [1:0] {
        TOK_VTX  = 2'd0,   // vertex
        TOK_MARK = 2'd1,   // end of polygon
        TOK_END  = 2'd2    // end of the results of one input word
    } tok_kind_t;

endpackage

// File: rtl/pcrw_if.sv
// Valid/ready channel interfaces for vertices in and clipped results out.
// No dependencies.
interface pcrw_vertex_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] vertex_x;
    logic signed [W-1:0] vertex_y;
    logic                final_vertex;

    modport source (output valid, vertex_x, vertex_y, final_vertex, input ready);
    modport sink   (input valid, vertex_x, vertex_y, final_vertex, output ready);
endinterface

interface pcrw_result_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] clipped_x;
    logic signed [W-1:0] clipped_y;
    logic                has_vertex;
    logic                polygon_done;
    logic                run_last;

    modport source (output valid, clipped_x, clipped_y, has_vertex, polygon_done, run_last,
                    input ready);
    modport sink   (input valid, clipped_x, clipped_y, has_vertex, polygon_done, run_last,
                    output ready);
endinterface

// File: rtl/pcrw_front.sv
// Front end: input word queue and token generator for the stage chain.
// Depends on pcrw_pkg.
module pcrw_front #(
    parameter int W = pcrw_pkg::COORD_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [W-1:0] in_x,
    input  logic signed [W-1:0] in_y,
    input  logic                in_final,
    output logic                tok_valid,
    input  logic                tok_ready,
    output logic [2*W+2:0]      tok
);
    import pcrw_pkg::*;

    typedef struct packed {
        tok_kind_t           kind;
        logic                fin;
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
    } tok_t;

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic                fin;
    } item_t;

    localparam int QD = 4;
    localparam int PW = $clog2(QD);

    item_t           q_mem [QD];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     cnt_reg, cnt_next;
    tok_kind_t       phase_reg, phase_next;
    item_t           head;
    tok_t            tok_c;
    logic            push, pop, tok_fire;

    assign head      = q_mem[rd_ptr_reg];
    assign in_ready  = (cnt_reg != (PW+1)'(QD));
    assign push      = in_valid && in_ready;
    assign tok_valid = (cnt_reg != '0);
    assign tok_fire  = tok_valid && tok_ready;
    assign pop       = tok_fire && (phase_reg == TOK_END);

    always_comb
    begin
        tok_c.kind = phase_reg;
        tok_c.fin  = head.fin;
        tok_c.x    = head.x;
        tok_c.y    = head.y;
    end
    assign tok = tok_c;

    always_comb
    begin
        phase_next = phase_reg;
        if (tok_fire)
        begin
            unique case (phase_reg)
                TOK_VTX:  phase_next = head.fin ? TOK_MARK : TOK_END;
                TOK_MARK: phase_next = TOK_END;
                default:  phase_next = TOK_VTX;
            endcase
        end
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{x: in_x, y: in_y, fin: in_final};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            phase_reg  <= TOK_VTX;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            phase_reg  <= phase_next;
        end
    end

endmodule

// File: rtl/pcrw_stage.sv
// One clip edge stage: keeps first/previous vertex, emits clipped vertices,
// and finds crossing points with a multiplier and a bit-serial divider.
// Depends on pcrw_pkg.
module pcrw_stage #(
    parameter int W     = pcrw_pkg::COORD_WIDTH_DEF,
    parameter int STAGE = pcrw_pkg::STG_LEFT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic signed [W-1:0] edge_val,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2*W+2:0]      in_tok,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2*W+2:0]      out_tok
);
    import pcrw_pkg::*;

    typedef struct packed {
        tok_kind_t           kind;
        logic                fin;
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
    } tok_t;

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
    } vtx_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    localparam bit IS_X   = (STAGE == STG_LEFT) || (STAGE == STG_RIGHT);
    localparam bit IS_MIN = (STAGE == STG_LEFT) || (STAGE == STG_TOP);
    localparam int W1     = W + 1;
    localparam int PW     = 2 * W1;
    localparam int CW     = $clog2(PW);

    function automatic logic inside_edge(input vtx_t v, input logic signed [W-1:0] e);
        logic signed [W-1:0] c;
        c = IS_X ? v.x : v.y;
        return IS_MIN ? (c >= e) : (c <= e);
    endfunction

    function automatic logic signed [W:0] sx(input logic signed [W-1:0] v);
        return {v[W-1], v};
    endfunction

    function automatic logic [W:0] mag(input logic signed [W:0] v);
        return v[W] ? W1'(-v) : W1'(v);
    endfunction

    state_t          state_reg, state_next;
    logic            started_reg, started_next;
    vtx_t            first_reg, first_next, prev_reg, prev_next;
    vtx_t            s_reg, s_next, p_reg, p_next;
    tok_kind_t       kind_reg, kind_next;
    logic            fin_reg, fin_next;
    logic            need_x_reg, need_x_next, need_p_reg, need_p_next;
    logic            need_pass_reg, need_pass_next;
    logic [PW-1:0]   dvd_reg, dvd_next;
    logic [W:0]      rem_reg, rem_next, den_reg, den_next;
    logic            neg_reg, neg_next, dzero_reg, dzero_next;
    logic [W-1:0]    sb_reg, sb_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;
    tok_t            out_tok_reg, out_tok_next;

    tok_t            tin;
    vtx_t            vin, es, ep;
    logic            si, pi, in_fire, out_free;
    logic signed [W-1:0] sa, pa, sb, pb;
    logic signed [W:0]   num1, num2, den;
    logic [W+1:0]        rem_sh;
    logic                ge;
    logic [W-1:0]        cut_val;
    vtx_t                xpt;

    assign tin      = tok_t'(in_tok);
    assign vin      = '{x: tin.x, y: tin.y};
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;

    // Edge ends as chosen at accept time
    assign es = (tin.kind == TOK_VTX) ? prev_reg : prev_reg;
    assign ep = (tin.kind == TOK_VTX) ? vin : first_reg;
    assign si = inside_edge(es, edge_val);
    assign pi = inside_edge(ep, edge_val);

    // Crossing arithmetic on the latched edge
    assign sa   = IS_X ? s_reg.x : s_reg.y;
    assign pa   = IS_X ? p_reg.x : p_reg.y;
    assign sb   = IS_X ? s_reg.y : s_reg.x;
    assign pb   = IS_X ? p_reg.y : p_reg.x;
    assign num1 = sx(pb) - sx(sb);
    assign num2 = sx(edge_val) - sx(sa);
    assign den  = sx(pa) - sx(sa);

    assign rem_sh = {rem_reg, dvd_reg[PW-1]};
    assign ge     = (rem_sh >= {1'b0, den_reg});

    assign cut_val = dzero_reg ? sb_reg
                   : (neg_reg ? sb_reg - dvd_reg[W-1:0] : sb_reg + dvd_reg[W-1:0]);
    assign xpt.x   = IS_X ? edge_val : cut_val;
    assign xpt.y   = IS_X ? cut_val : edge_val;

    always_comb
    begin
        state_next     = state_reg;
        started_next   = started_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        s_next         = s_reg;
        p_next         = p_reg;
        kind_next      = kind_reg;
        fin_next       = fin_reg;
        need_x_next    = need_x_reg;
        need_p_next    = need_p_reg;
        need_pass_next = need_pass_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        dzero_next     = dzero_reg;
        sb_next        = sb_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_tok_next   = out_tok_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    kind_next      = tin.kind;
                    fin_next       = tin.fin;
                    s_next         = es;
                    p_next         = ep;
                    need_x_next    = 1'b0;
                    need_p_next    = 1'b0;
                    need_pass_next = 1'b0;
                    unique case (tin.kind)
                        TOK_VTX:
                        begin
                            prev_next = vin;
                            if (!started_reg)
                            begin
                                first_next   = vin;
                                started_next = 1'b1;
                            end
                            else
                            begin
                                need_x_next = si ^ pi;
                                need_p_next = pi;
                            end
                        end
                        TOK_MARK:
                        begin
                            need_x_next    = started_reg && (si ^ pi);
                            need_p_next    = started_reg && pi;
                            need_pass_next = 1'b1;
                            started_next   = 1'b0;
                        end
                        default:
                        begin
                            need_pass_next = 1'b1;
                        end
                    endcase
                    if (need_x_next)
                        state_next = S_MUL;
                    else if (need_p_next || need_pass_next)
                        state_next = S_EMIT;
                end
            end
            S_MUL:
            begin
                dvd_next   = mag(num1) * mag(num2);
                rem_next   = '0;
                den_next   = mag(den);
                dzero_next = (den == '0);
                neg_next   = num1[W] ^ num2[W] ^ den[W];
                sb_next    = sb;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = ge ? W1'(rem_sh - {1'b0, den_reg}) : rem_sh[W:0];
                dvd_next = {dvd_reg[PW-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(PW - 1))
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    priority if (need_x_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_tok_next   = '{kind: TOK_VTX, fin: fin_reg, x: xpt.x, y: xpt.y};
                        need_x_next    = 1'b0;
                    end
                    else if (need_p_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_tok_next   = '{kind: TOK_VTX, fin: fin_reg, x: p_reg.x, y: p_reg.y};
                        need_p_next    = 1'b0;
                    end
                    else if (need_pass_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_tok_next   = '{kind: kind_reg, fin: fin_reg, x: '0, y: '0};
                        need_pass_next = 1'b0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        first_reg     <= first_next;
        prev_reg      <= prev_next;
        s_reg         <= s_next;
        p_reg         <= p_next;
        kind_reg      <= kind_next;
        fin_reg       <= fin_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        neg_reg       <= neg_next;
        dzero_reg     <= dzero_next;
        sb_reg        <= sb_next;
        cnt_reg       <= cnt_next;
        out_tok_reg   <= out_tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            need_x_reg    <= 1'b0;
            need_p_reg    <= 1'b0;
            need_pass_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            need_x_reg    <= need_x_next;
            need_p_reg    <= need_p_next;
            need_pass_reg <= need_pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/pcrw_emit.sv
// Result end: caps results per input word, holds one result back so the
// last one of each run can be flagged, and drives the output register.
// Depends on pcrw_pkg.
module pcrw_emit #(
    parameter int W = pcrw_pkg::COORD_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tok_valid,
    output logic                tok_ready,
    input  logic [2*W+2:0]      tok,
    output logic                res_valid,
    input  logic                res_ready,
    output logic signed [W-1:0] res_x,
    output logic signed [W-1:0] res_y,
    output logic                res_has,
    output logic                res_done,
    output logic                res_last
);
    import pcrw_pkg::*;

    typedef struct packed {
        tok_kind_t           kind;
        logic                fin;
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
    } tok_t;

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic                has;
        logic                done;
        logic                last;
    } res_t;

    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    tok_t             t;
    logic             pend_valid_reg, pend_valid_next;
    res_t             pend_reg, pend_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next, limit;
    logic             out_valid_reg, out_valid_next;
    res_t             out_reg, out_next;
    logic             out_free, drop, fire;

    assign t        = tok_t'(tok);
    assign out_free = !out_valid_reg || res_ready;
    assign limit    = t.fin ? CNT_W'(MAX_RESULTS - 1) : CNT_W'(MAX_RESULTS);
    assign drop     = (t.kind == TOK_VTX) && (cnt_reg >= limit);
    assign tok_ready = drop || !pend_valid_reg || out_free;
    assign fire     = tok_valid && tok_ready;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_next        = out_reg;
        if (fire && !drop)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_next.last  = (t.kind == TOK_END);
            end
            unique case (t.kind)
                TOK_VTX:
                begin
                    pend_valid_next = 1'b1;
                    pend_next       = '{x: t.x, y: t.y, has: 1'b1, done: 1'b0, last: 1'b0};
                    cnt_next        = cnt_reg + 1'b1;
                end
                TOK_MARK:
                begin
                    pend_valid_next = 1'b1;
                    pend_next       = '{x: '0, y: '0, has: 1'b0, done: 1'b1, last: 1'b0};
                    cnt_next        = cnt_reg + 1'b1;
                end
                default:
                begin
                    pend_valid_next = 1'b0;
                    cnt_next        = '0;
                end
            endcase
        end
    end

    assign res_valid = out_valid_reg;
    assign res_x     = out_reg.x;
    assign res_y     = out_reg.y;
    assign res_has   = out_reg.has;
    assign res_done  = out_reg.done;
    assign res_last  = out_reg.last;

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

// File: rtl/polygon_clip_rect_window.sv
// Channel       | dir | handshake      | payload
// vertex_in     | in  | valid/ready    | vertex_x, vertex_y, final_vertex
// result_out    | out | valid/ready    | clipped_x, clipped_y, has_vertex, polygon_done, run_last
// cfg           | in  | cfg_we         | cfg_idx, cfg_data
//
// A word is tokenized (vertex, polygon marker, run end) and passes the left, right, top and bottom edge stages.
// A stage accepts a token in S_IDLE; when an edge crosses its window side it runs S_MUL, then the
// serial divider in S_DIV; it emits each word in S_EMIT and takes no new token until back in S_IDLE.
// Reset clears stage and queue control; vertex storage is loaded on first use.
// Each stage and the result end stall only on their own downstream word.
// Depends on pcrw_pkg, pcrw_if, pcrw_front, pcrw_stage, pcrw_emit.
module polygon_clip_rect_window #(
    parameter int COORD_WIDTH = pcrw_pkg::COORD_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pcrw_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [COORD_WIDTH-1:0]         cfg_data,
    pcrw_vertex_if.sink                    vertex_in,
    pcrw_result_if.source                  result_out
);
    import pcrw_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int NS = 4;
    localparam int TW = 2 * W + 3;

    logic signed [W-1:0] left_reg, top_reg, right_reg, bottom_reg;
    logic signed [W-1:0] edge_val [NS];
    logic                ch_valid [NS+1];
    logic                ch_ready [NS+1];
    logic [TW-1:0]       ch_tok   [NS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= W'(RST_LEFT);
            top_reg    <= W'(RST_TOP);
            right_reg  <= W'(RST_RIGHT);
            bottom_reg <= W'(RST_BOTTOM);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_LEFT:   left_reg   <= cfg_data;
                CFG_TOP:    top_reg    <= cfg_data;
                CFG_RIGHT:  right_reg  <= cfg_data;
                CFG_BOTTOM: bottom_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign edge_val[STG_LEFT]   = left_reg;
    assign edge_val[STG_RIGHT]  = right_reg;
    assign edge_val[STG_TOP]    = top_reg;
    assign edge_val[STG_BOTTOM] = bottom_reg;

    pcrw_front #(.W(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vertex_in.valid),
        .in_ready  (vertex_in.ready),
        .in_x      (vertex_in.vertex_x),
        .in_y      (vertex_in.vertex_y),
        .in_final  (vertex_in.final_vertex),
        .tok_valid (ch_valid[0]),
        .tok_ready (ch_ready[0]),
        .tok       (ch_tok[0])
    );

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        pcrw_stage #(.W(W), .STAGE(k)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .edge_val  (edge_val[k]),
            .in_valid  (ch_valid[k]),
            .in_ready  (ch_ready[k]),
            .in_tok    (ch_tok[k]),
            .out_valid (ch_valid[k+1]),
            .out_ready (ch_ready[k+1]),
            .out_tok   (ch_tok[k+1])
        );
    end

    pcrw_emit #(.W(W)) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (ch_valid[NS]),
        .tok_ready (ch_ready[NS]),
        .tok       (ch_tok[NS]),
        .res_valid (result_out.valid),
        .res_ready (result_out.ready),
        .res_x     (result_out.clipped_x),
        .res_y     (result_out.clipped_y),
        .res_has   (result_out.has_vertex),
        .res_done  (result_out.polygon_done),
        .res_last  (result_out.run_last)
    );

endmodule

// File: rtl/pcrw_checker.sv
// Port-level checks on the result channel of the clipper, and their binding.
// Depends on pcrw_pkg and polygon_clip_rect_window.
module pcrw_checker #(
    parameter int W = pcrw_pkg::COORD_WIDTH_DEF
) (
    input logic         clk,
    input logic         rst_n,
    input logic         valid,
    input logic         ready,
    input logic [W-1:0] cx,
    input logic [W-1:0] cy,
    input logic         has_vertex,
    input logic         polygon_done,
    input logic         run_last
);
    // stalled result word holds its coordinates and run_last
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(cx) && $stable(cy) && $stable(run_last))
        else $error("result word changed while stalled");

    // every word carries a vertex or is the polygon marker
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (has_vertex != polygon_done))
        else $error("result word neither vertex nor marker");

    // the polygon marker always closes its run and carries zero coordinates
    a_mark: assert property (@(posedge clk) disable iff (!rst_n)
        valid && polygon_done |-> run_last && (cx == '0) && (cy == '0))
        else $error("polygon marker malformed");

    a_rst: assert property (@(posedge clk) $rose(rst_n) |-> !valid)
        else $error("result valid out of reset");
endmodule

bind polygon_clip_rect_window pcrw_checker #(.W(COORD_WIDTH)) u_pcrw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (result_out.valid),
    .ready        (result_out.ready),
    .cx           (result_out.clipped_x),
    .cy           (result_out.clipped_y),
    .has_vertex   (result_out.has_vertex),
    .polygon_done (result_out.polygon_done),
    .run_last     (result_out.run_last)
);

// File: tb/polygon_clip_rect_window_test.sv
// Testbench for polygon_clip_rect_window: directed and random polygons, checked
// against a behavioral clipper. Depends on pcrw_pkg, pcrw_if and the clipper RTL.
`timescale 1ns / 100ps

module polygon_clip_rect_window_test;
    import pcrw_pkg::*;

    localparam int CW       = 16;
    localparam int WDOG_MAX = 20000;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } point_t;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          has;
        logic          done;
        logic          last;
    } clip_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CW-1:0] cfg_data = '0;

    pcrw_vertex_if #(.W(CW)) vin ();
    pcrw_result_if #(.W(CW)) vout ();

    polygon_clip_rect_window #(.COORD_WIDTH(CW)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .vertex_in(vin.sink), .result_out(vout.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clipper state
    logic signed [CW-1:0] win_left, win_top, win_right, win_bottom;
    point_t first_pt [4];
    point_t prev_pt [4];
    bit     started [4];
    clip_word_t pending [$];
    clip_word_t expected_words [$];
    int     run_limit;
    int     error_count = 0;
    int     wdog = 0;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    function automatic logic signed [CW-1:0] cross_coord(
        input logic signed [CW-1:0] sa, pa, sb, pb, e);
        longint num1, num2, den, prod, q;
        num1 = longint'(pb) - longint'(sb);
        num2 = longint'(e) - longint'(sa);
        den  = longint'(pa) - longint'(sa);
        if (den == 0)
            return sb;
        prod = num1 * num2;
        q = prod / den;   // truncates toward zero
        return CW'(longint'(sb) + q);
    endfunction

    function automatic bit inside_edge(input int k, input point_t v);
        case (k)
            STG_LEFT:  return v.x >= win_left;
            STG_RIGHT: return v.x <= win_right;
            STG_TOP:   return v.y >= win_top;
            default:   return v.y <= win_bottom;
        endcase
    endfunction

    function automatic point_t edge_cross(input int k, input point_t s, input point_t p);
        point_t r;
        if (k == STG_LEFT || k == STG_RIGHT)
        begin
            r.x = (k == STG_LEFT) ? win_left : win_right;
            r.y = cross_coord(s.x, p.x, s.y, p.y, r.x);
        end
        else
        begin
            r.y = (k == STG_TOP) ? win_top : win_bottom;
            r.x = cross_coord(s.y, p.y, s.x, p.x, r.y);
        end
        return r;
    endfunction

    function automatic void push_word(input point_t v, input bit marker);
        clip_word_t w;
        if (!marker && pending.size() >= run_limit)
            return;
        if (pending.size() >= MAX_RESULTS)
            return;
        w.x = marker ? '0 : v.x;
        w.y = marker ? '0 : v.y;
        w.has = !marker;
        w.done = marker;
        w.last = 1'b0;
        pending.push_back(w);
    endfunction

    function automatic void clip_stage(input int k, input point_t v, input bit marker);
        point_t s;
        bit si, pi;
        if (k >= 4)
        begin
            push_word(v, marker);
            return;
        end
        if (marker)
        begin
            if (started[k])
            begin
                s = prev_pt[k];
                si = inside_edge(k, s);
                pi = inside_edge(k, first_pt[k]);
                if (si && pi)
                    clip_stage(k + 1, first_pt[k], 0);
                else if (si)
                    clip_stage(k + 1, edge_cross(k, s, first_pt[k]), 0);
                else if (pi)
                begin
                    clip_stage(k + 1, edge_cross(k, s, first_pt[k]), 0);
                    clip_stage(k + 1, first_pt[k], 0);
                end
            end
            started[k] = 0;
            clip_stage(k + 1, v, 1);
            return;
        end
        if (!started[k])
        begin
            first_pt[k] = v;
            started[k] = 1;
        end
        else
        begin
            s = prev_pt[k];
            si = inside_edge(k, s);
            pi = inside_edge(k, v);
            if (si && pi)
                clip_stage(k + 1, v, 0);
            else if (si)
                clip_stage(k + 1, edge_cross(k, s, v), 0);
            else if (pi)
            begin
                clip_stage(k + 1, edge_cross(k, s, v), 0);
                clip_stage(k + 1, v, 0);
            end
        end
        prev_pt[k] = v;
    endfunction

    function automatic void predict_vertex(input point_t v, input bit fin);
        point_t z;
        z = '0;
        pending.delete();
        run_limit = fin ? MAX_RESULTS - 1 : MAX_RESULTS;
        clip_stage(0, v, 0);
        if (fin)
            clip_stage(0, z, 1);
        if (pending.size() > 0)
            pending[pending.size() - 1].last = 1'b1;
        foreach (pending[i])
            expected_words.push_back(pending[i]);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LEFT:   win_left = val;
            CFG_TOP:    win_top = val;
            CFG_RIGHT:  win_right = val;
            CFG_BOTTOM: win_bottom = val;
            default: ;
        endcase
    endtask

    // Waits for the pipeline to drain before touching the window registers;
    // words with no results may still be in the stages after the last result
    task automatic drain;
        vin.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);
    endtask

    task automatic set_window(input int l, t, r, b);
        drain();
        write_reg(CFG_LEFT, CW'(l));
        write_reg(CFG_TOP, CW'(t));
        write_reg(CFG_RIGHT, CW'(r));
        write_reg(CFG_BOTTOM, CW'(b));
    endtask

    // valid stays high after a word is taken; the next call drops it only when it inserts a gap, and drain drops it
    task automatic send_vertex(input logic [CW-1:0] x, y, input bit fin);
        point_t p;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            vin.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vin.valid <= 1'b1;
        vin.vertex_x <= x;
        vin.vertex_y <= y;
        vin.final_vertex <= fin;
        @(posedge clk);
        while (!vin.ready)
            @(posedge clk);
        p.x = x;
        p.y = y;
        predict_vertex(p, fin);
    endtask

    task automatic test_directed;
        // extremes, square crossing every edge, single vertex, fully clipped
        send_vertex(16'h8000, 16'h8000, 0);
        send_vertex(16'h7fff, 16'h7fff, 0);
        send_vertex(16'h7fff, 16'h8000, 1);
        send_vertex(CW'(1000), CW'(1000), 0);
        send_vertex(CW'(7000), CW'(1000), 0);
        send_vertex(CW'(7000), CW'(6000), 0);
        send_vertex(CW'(1000), CW'(6000), 1);
        send_vertex(CW'(4000), CW'(3000), 1);
        send_vertex(CW'(100), CW'(3000), 1);
        send_vertex(CW'(100), CW'(100), 0);
        send_vertex(CW'(200), CW'(100), 0);
        send_vertex(CW'(150), CW'(200), 1);
        send_vertex(CW'(3000), CW'(3000), 0);
        send_vertex(CW'(5000), CW'(4000), 0);
        send_vertex(CW'(-30000), CW'(30000), 1);
        send_vertex(16'hffff, 16'h0000, 0);
        send_vertex(16'h5555, 16'haaaa, 0);
        send_vertex(16'haaaa, 16'h5555, 1);
    endtask

    task automatic test_random_polygons(input int n_items, input int spread);
        int sent, nv;
        sent = 0;
        while (sent < n_items)
        begin
            nv = $urandom_range(1, 7);
            for (int i = 0; i < nv; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_vertex(CW'($urandom), CW'($urandom), i == nv - 1);
                else
                    send_vertex(CW'(4000 + $urandom_range(0, 2 * spread) - spread),
                                CW'(3600 + $urandom_range(0, 2 * spread) - spread),
                                i == nv - 1);
                sent++;
            end
        end
    endtask

    task automatic test_extreme_window;
        set_window(-32768, -32768, 32767, 32767);
        test_random_polygons(20, 20000);
        set_window(32767, 32767, -32768, -32768);
        test_random_polygons(15, 3000);
        set_window(0, 0, 0, 0);
        test_random_polygons(15, 3000);
    endtask

    task automatic test_quiet_pause;
        test_random_polygons(10, 3000);
        vin.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        test_random_polygons(10, 3000);
    endtask

    // Result checker with random backpressure
    always @(posedge clk)
    begin
        clip_word_t got, want;
        if (rst_n && vout.valid && vout.ready)
        begin
            got = {vout.clipped_x, vout.clipped_y, vout.has_vertex,
                   vout.polygon_done, vout.run_last};
            if (expected_words.size() == 0)
                report("unexpected result word");
            else
            begin
                want = expected_words.pop_front();
                if (got.x !== want.x)
                    report($sformatf("x got %h want %h", got.x, want.x));
                if (got.y !== want.y)
                    report($sformatf("y got %h want %h", got.y, want.y));
                if (got.has !== want.has)
                    report($sformatf("has_vertex got %b want %b", got.has, want.has));
                if (got.done !== want.done)
                    report($sformatf("polygon_done got %b want %b", got.done, want.done));
                if (got.last !== want.last)
                    report($sformatf("run_last got %b want %b", got.last, want.last));
            end
        end
    end

    int stall_left = 0;
    always @(posedge clk)
    begin
        if (vout.valid && vout.ready || stall_left == 0 && !vout.ready)
        begin
            if (stall_left == 0 && !vout.ready)
                vout.ready <= 1'b1;
            else
            begin
                stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                vout.ready <= (stall_left == 0);
            end
        end
        else if (stall_left > 0)
            stall_left = stall_left - 1;
    end

    always @(posedge clk)
    begin
        if ((vin.valid && vin.ready) || (vout.valid && vout.ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        vin.valid = 1'b0;
        vin.vertex_x = '0;
        vin.vertex_y = '0;
        vin.final_vertex = 1'b0;
        vout.ready = 1'b0;
        win_left = CW'(RST_LEFT);
        win_top = CW'(RST_TOP);
        win_right = CW'(RST_RIGHT);
        win_bottom = CW'(RST_BOTTOM);
        foreach (started[i])
            started[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_polygons(90, 3000);
        test_quiet_pause();
        test_extreme_window();
        set_window(2000, 1000, 6000, 5000);
        test_random_polygons(40, 4000);
        drain();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
